[rtl/dohc_pkg.sv]
// Shared types, codes and constants for the delayed on/off heater control core.
package dohc_pkg;

    localparam int unsigned DELAY_W   = 10;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned MODE_W    = 2;
    // delay * 1000 stays below 2^20 for any delay up to the limit
    localparam int unsigned ELAPSED_W = 20;

    localparam logic [DELAY_W-1:0]   DELAY_LIMIT = 10'd1000;
    localparam logic [ELAPSED_W-1:0] MS_PER_SEC  = 20'd1000;

    // floor(x / 1000) for x < 1e6: (x >> 3) * ceil(2^24 / 125) >> 24
    localparam int unsigned          DIV_PRE_SHIFT = 3;
    localparam int unsigned          QUOT_W        = ELAPSED_W - DIV_PRE_SHIFT;
    localparam int unsigned          RECIP_W       = 18;
    localparam int unsigned          RECIP_SHIFT   = 24;
    localparam logic [RECIP_W-1:0]   RECIP_125     = 18'd134218;
    localparam int unsigned          PROD_W        = QUOT_W + RECIP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAY = 2'd1;

    localparam logic [MODE_W-1:0] MODE_OFF       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELAY_ON  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ON        = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DELAY_OFF = 2'd3;

    typedef enum logic [3:0] {
        ST_OFF       = 4'b0001,
        ST_DELAY_ON  = 4'b0010,
        ST_ON        = 4'b0100,
        ST_DELAY_OFF = 4'b1000
    } t_state;

    typedef struct packed {
        logic              heat_request;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               heater_drive;
        logic [DELAY_W-1:0] seconds_to_change;
    } t_out_item;

    // Per-request result of the state update, handed to the countdown stages
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               drive;
        logic               in_delay;
        logic [DELAY_W-1:0] delay_s;
        logic [TIME_W-1:0]  start_ms;
        logic [TIME_W-1:0]  now_ms;
    } t_fsm_res;

    function automatic logic [ELAPSED_W-1:0] delay_ms(input logic [DELAY_W-1:0] d);
        return ELAPSED_W'(d) * MS_PER_SEC;
    endfunction

endpackage

[rtl/dohc_fsm.sv]
// Heater state machine, delay registers and delay start time.
module dohc_fsm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  dohc_pkg::t_in_item           i_req,
    input  logic                         i_cfg_we,
    input  logic [dohc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dohc_pkg::DELAY_W-1:0] i_cfg_data,
    output dohc_pkg::t_fsm_res           o_res
);
    import dohc_pkg::*;

    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_start, n_start;
    logic                r_prev;
    logic [DELAY_W-1:0]  r_on_delay, r_off_delay;

    logic [DELAY_W-1:0]  wait_delay;
    logic [TIME_W-1:0]   limit_ms;
    logic                expired;

    always_comb begin
        wait_delay = (r_state == ST_DELAY_ON) ? r_on_delay : r_off_delay;
        limit_ms   = r_start + TIME_W'(delay_ms(wait_delay));
        expired    = limit_ms < i_req.now_ms;

        n_state = r_state;
        n_start = r_start;
        case (r_state)
            ST_OFF: begin
                // only a rising request edge arms the on delay
                if (i_req.heat_request && !r_prev) begin
                    n_state = ST_DELAY_ON;
                    n_start = i_req.now_ms;
                end
            end
            ST_DELAY_ON: begin
                if (i_req.heat_request && expired) begin
                    n_state = ST_ON;
                end else if (!i_req.heat_request) begin
                    n_state = ST_OFF;
                end
            end
            ST_ON: begin
                if (!i_req.heat_request) begin
                    n_state = ST_DELAY_OFF;
                    n_start = i_req.now_ms;
                end
            end
            ST_DELAY_OFF: begin
                if (!i_req.heat_request && expired) begin
                    n_state = ST_OFF;
                end else if (i_req.heat_request) begin
                    n_state = ST_ON;
                end
            end
            default: begin
                n_state = ST_OFF;
            end
        endcase
    end

    always_comb begin
        case (n_state)
            ST_DELAY_ON:  o_res.mode = MODE_DELAY_ON;
            ST_ON:        o_res.mode = MODE_ON;
            ST_DELAY_OFF: o_res.mode = MODE_DELAY_OFF;
            default:      o_res.mode = MODE_OFF;
        endcase
        o_res.drive    = (n_state == ST_ON) || (n_state == ST_DELAY_OFF);
        o_res.in_delay = (n_state == ST_DELAY_ON) || (n_state == ST_DELAY_OFF);
        o_res.delay_s  = (n_state == ST_DELAY_ON) ? r_on_delay : r_off_delay;
        o_res.start_ms = n_start;
        o_res.now_ms   = i_req.now_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_OFF;
            r_start <= '0;
            r_prev  <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_start <= n_start;
            r_prev  <= i_req.heat_request;
        end
    end

    // drop out-of-range delays and unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_delay  <= '0;
            r_off_delay <= '0;
        end else if (i_cfg_we && (i_cfg_data <= DELAY_LIMIT)) begin
            if (i_cfg_idx == CFG_ON_DELAY) begin
                r_on_delay <= i_cfg_data;
            end else if (i_cfg_idx == CFG_OFF_DELAY) begin
                r_off_delay <= i_cfg_data;
            end
        end
    end

endmodule

[rtl/delayed_on_off_heater_control_core.sv]
// Top level of the delayed on/off heater control core: request pipeline and countdown.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+--------------------------------------
//  request  | i_in_valid / o_in_stall    | i_in_item  (heat_request, now_ms)
//  result   | o_out_valid / i_out_stall  | o_out_item (mode, heater_drive,
//           |                            |             seconds_to_change)
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One request per cycle is taken while o_in_stall is low; each gives one result.
// Stages: input register, state update, elapsed-time compare, divide by 1000 into
// the output register. Every stage holds its request while the next one is full and
// stalled, so a stall on the result side reaches o_in_stall only once all stages fill.
// Synchronous active-low reset empties the pipeline, returns the heater to off and
// clears both delays to zero.
module delayed_on_off_heater_control_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  dohc_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output dohc_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_we,
    input  logic [dohc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dohc_pkg::DELAY_W-1:0]   i_cfg_data
);
    import dohc_pkg::*;

    logic                 r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_in_item             r_s1_item;
    t_fsm_res             r_s2_res;
    t_fsm_res             fsm_res;

    logic [MODE_W-1:0]    r_s3_mode;
    logic                 r_s3_drive;
    logic                 r_s3_zero;
    logic [DELAY_W-1:0]   r_s3_delay;
    logic [ELAPSED_W-1:0] r_s3_elapsed;
    t_out_item            r_out_item;

    logic                 out_ready, s3_ready, s2_ready, s1_ready;
    logic [TIME_W-1:0]    elapsed_ms;
    logic                 n_s3_zero;
    logic [PROD_W-1:0]    quot_prod;
    logic [DELAY_W-1:0]   elapsed_s;
    t_out_item            n_out_item;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s3_ready   = !r_s3_valid || out_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;

    dohc_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (r_s1_valid && s2_ready),
        .i_req      (r_s1_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (fsm_res)
    );

    // Countdown is zero outside a delay and saturates once elapsed time reaches the whole delay
    always_comb begin
        elapsed_ms = r_s2_res.now_ms - r_s2_res.start_ms;
        n_s3_zero  = !r_s2_res.in_delay
                  || (elapsed_ms >= TIME_W'(delay_ms(r_s2_res.delay_s)));
    end

    // Below saturation elapsed is under 1e6 ms, so the reciprocal divide is exact
    always_comb begin
        quot_prod = PROD_W'(r_s3_elapsed[ELAPSED_W-1:DIV_PRE_SHIFT]) * PROD_W'(RECIP_125);
        elapsed_s = quot_prod[RECIP_SHIFT +: DELAY_W];
        n_out_item.mode              = r_s3_mode;
        n_out_item.heater_drive      = r_s3_drive;
        n_out_item.seconds_to_change = r_s3_zero ? '0 : (r_s3_delay - elapsed_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_res <= fsm_res;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_mode    <= r_s2_res.mode;
            r_s3_drive   <= r_s2_res.drive;
            r_s3_zero    <= n_s3_zero;
            r_s3_delay   <= r_s2_res.delay_s;
            r_s3_elapsed <= elapsed_ms[ELAPSED_W-1:0];
        end
        if (out_ready && r_s3_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
